### rtl/ptll_pkg.sv
`timescale 1ns / 1ps

package ptll_pkg;

    localparam int DW      = 33;
    localparam int CW      = 36;
    localparam int ZW      = 18;
    localparam int AW      = 17;
    localparam int TAB_LEN = 24;

    localparam logic signed [ZW-1:0] Q_PI      = 18'sd102944;
    localparam logic signed [ZW-1:0] Q_HALF_PI = 18'sd51472;

    typedef enum logic [1:0] {
        REG_CENTRE_X      = 2'd0,
        REG_CENTRE_Y      = 2'd1,
        REG_CENTRE_Z      = 2'd2,
        REG_PLANET_RADIUS = 2'd3
    } cfg_reg_t;

    function automatic logic [15:0] atan_q15(input int unsigned idx);
        logic [15:0] val;
        case (idx)
            0:       val = 16'd25736;
            1:       val = 16'd15193;
            2:       val = 16'd8027;
            3:       val = 16'd4075;
            4:       val = 16'd2045;
            5:       val = 16'd1024;
            6:       val = 16'd512;
            7:       val = 16'd256;
            8:       val = 16'd128;
            9:       val = 16'd64;
            10:      val = 16'd32;
            11:      val = 16'd16;
            12:      val = 16'd8;
            13:      val = 16'd4;
            14:      val = 16'd2;
            15:      val = 16'd1;
            default: val = 16'd0;
        endcase
        return val;
    endfunction

endpackage

### rtl/ptll_if.sv
`timescale 1ns / 1ps

interface ptll_pt_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;

    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface ptll_res_if;
    logic        valid;
    logic        ready;
    logic [17:0] latitude;
    logic [17:0] longitude;
    logic [31:0] noise_u;
    logic [31:0] noise_v;
    logic        at_centre;

    modport source (output valid, latitude, longitude, noise_u, noise_v, at_centre,
                    input ready);
    modport sink   (input valid, latitude, longitude, noise_u, noise_v, at_centre,
                    output ready);
endinterface

### rtl/ptll_cordic.sv
`timescale 1ns / 1ps

module ptll_cordic #(
    parameter int ITER = 16,
    parameter int SW   = 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_vld,
    input  logic signed [ptll_pkg::CW-1:0] in_y,
    input  logic signed [ptll_pkg::CW-1:0] in_x,
    input  logic [SW-1:0]                  in_side,
    output logic                           out_vld,
    output logic signed [ptll_pkg::ZW-1:0] out_z,
    output logic [SW-1:0]                  out_side
);

    localparam int N = (ITER < ptll_pkg::TAB_LEN) ? ITER : ptll_pkg::TAB_LEN;

    logic                           vld_reg  [0:N];
    logic signed [ptll_pkg::CW-1:0] x_reg    [0:N];
    logic signed [ptll_pkg::CW-1:0] y_reg    [0:N];
    logic signed [ptll_pkg::ZW-1:0] z_reg    [0:N];
    logic [SW-1:0]                  side_reg [0:N];

    logic signed [ptll_pkg::CW-1:0] x0_next;
    logic signed [ptll_pkg::CW-1:0] y0_next;
    logic signed [ptll_pkg::ZW-1:0] z0_next;

    // rotate the left half plane onto the right half plane
    always_comb
    begin
        x0_next = in_x;
        y0_next = in_y;
        z0_next = '0;
        if (in_x < 0)
        begin
            if (in_y >= 0)
            begin
                x0_next = in_y;
                y0_next = -in_x;
                z0_next = ptll_pkg::Q_HALF_PI;
            end
            else
            begin
                x0_next = -in_y;
                y0_next = in_x;
                z0_next = -ptll_pkg::Q_HALF_PI;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            z_reg[0]    <= z0_next;
            side_reg[0] <= in_side;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic signed [ptll_pkg::CW-1:0] xs;
        logic signed [ptll_pkg::CW-1:0] ys;
        logic signed [ptll_pkg::ZW-1:0] ang;

        assign xs  = x_reg[i] >>> i;
        assign ys  = y_reg[i] >>> i;
        assign ang = $signed({2'b00, ptll_pkg::atan_q15(i)});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (en)
                vld_reg[i+1] <= vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i+1] <= side_reg[i];
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + ang;
                end
                else if (y_reg[i] < 0)
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - ang;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i];
                    y_reg[i+1] <= y_reg[i];
                    z_reg[i+1] <= z_reg[i];
                end
            end
        end
    end

    assign out_vld  = vld_reg[N];
    assign out_z    = z_reg[N];
    assign out_side = side_reg[N];

endmodule

### rtl/ptll_isqrt.sv
`timescale 1ns / 1ps

module ptll_isqrt #(
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_vld,
    input  logic [63:0]   in_v,
    input  logic [SW-1:0] in_side,
    output logic          out_vld,
    output logic [31:0]   out_root,
    output logic [SW-1:0] out_side
);

    localparam int NS = 32;

    logic          vld_reg  [0:NS];
    logic [63:0]   v_reg    [0:NS];
    logic [63:0]   r_reg    [0:NS];
    logic [SW-1:0] side_reg [0:NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg[0]    <= in_v;
            r_reg[0]    <= '0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] trial;

        assign trial = r_reg[k] + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k+1] <= side_reg[k];
                if (v_reg[k] >= trial)
                begin
                    v_reg[k+1] <= v_reg[k] - trial;
                    r_reg[k+1] <= (r_reg[k] >> 1) + BIT;
                end
                else
                begin
                    v_reg[k+1] <= v_reg[k];
                    r_reg[k+1] <= r_reg[k] >> 1;
                end
            end
        end
    end

    assign out_vld  = vld_reg[NS];
    assign out_root = r_reg[NS][31:0];
    assign out_side = side_reg[NS];

endmodule

### rtl/ptll_noise.sv
`timescale 1ns / 1ps

module ptll_noise #(
    parameter int WORLD_UNITS_PER_NODE = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_vld,
    input  logic signed [ptll_pkg::ZW-1:0] in_lat,
    input  logic signed [ptll_pkg::ZW-1:0] in_lon,
    input  logic                           in_centre,
    input  logic [30:0]                    radius,
    output logic                           out_vld,
    output logic [ptll_pkg::ZW-1:0]        out_lat,
    output logic [ptll_pkg::ZW-1:0]        out_lon,
    output logic [31:0]                    out_u,
    output logic [31:0]                    out_v,
    output logic                           out_centre
);

    localparam int ZW   = ptll_pkg::ZW;
    localparam int AW   = ptll_pkg::AW;
    localparam int NB   = 34;
    localparam int MW   = 35;
    localparam int PW   = 36;
    localparam int SUMW = 80;
    localparam int LAST = 4;
    localparam int SH   = NB + $clog2(WORLD_UNITS_PER_NODE);
    localparam logic [63:0] RECIP_W = ((64'd1 << SH) + 64'(WORLD_UNITS_PER_NODE) - 64'd1)
                                      / 64'(WORLD_UNITS_PER_NODE);
    localparam logic [MW-1:0] RECIP = RECIP_W[MW-1:0];
    localparam logic [48:0]   HALF  = 49'(WORLD_UNITS_PER_NODE) << 14;

    function automatic logic signed [ZW-1:0] clamp(input logic signed [ZW-1:0] v,
                                                   input logic signed [ZW-1:0] lim);
        logic signed [ZW-1:0] r;
        if (v > lim)
            r = lim;
        else if (v < -lim)
            r = -lim;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [31:0] saturate(input logic [NB-1:0] q, input logic neg);
        logic [31:0] r;
        if (!neg)
            r = (q > 34'h07FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
        else
            r = (q > 34'h080000000) ? 32'h80000000 : ~q[31:0] + 32'd1;
        return r;
    endfunction

    function automatic logic [PW-1:0] part(input logic [17:0] a, input logic [17:0] b);
        return {18'd0, a} * {18'd0, b};
    endfunction

    logic                    vld_reg [0:LAST];
    logic signed [ZW-1:0]    lat_reg [0:LAST];
    logic signed [ZW-1:0]    lon_reg [0:LAST];
    logic                    cen_reg [0:LAST];
    logic [AW-1:0]           au_reg;
    logic [AW-1:0]           av_reg;
    logic [47:0]             mu_reg;
    logic [47:0]             mv_reg;
    logic [NB-1:0]           nu_reg;
    logic [NB-1:0]           nv_reg;
    logic [PW-1:0]           pu_reg  [0:3];
    logic [PW-1:0]           pv_reg  [0:3];
    logic [NB-1:0]           qu_reg;
    logic [NB-1:0]           qv_reg;

    logic signed [ZW-1:0]    lat_c;
    logic signed [ZW-1:0]    lon_c;
    logic [48:0]             su;
    logic [48:0]             sv;
    logic [SUMW-1:0]         sum_u;
    logic [SUMW-1:0]         sum_v;

    assign lat_c = clamp(in_lat, ptll_pkg::Q_HALF_PI);
    assign lon_c = clamp(in_lon, ptll_pkg::Q_PI);
    assign su    = {1'b0, mu_reg} + HALF;
    assign sv    = {1'b0, mv_reg} + HALF;

    // reciprocal multiply, summed from four partial products
    assign sum_u = ({44'd0, pu_reg[0]} << 34) + ({44'd0, pu_reg[1]} << 17)
                 + ({44'd0, pu_reg[2]} << 17) + {44'd0, pu_reg[3]};
    assign sum_v = ({44'd0, pv_reg[0]} << 34) + ({44'd0, pv_reg[1]} << 17)
                 + ({44'd0, pv_reg[2]} << 17) + {44'd0, pv_reg[3]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lat_reg[0] <= lat_c;
            lon_reg[0] <= lon_c;
            cen_reg[0] <= in_centre;
            au_reg     <= lon_c[ZW-1] ? AW'(-lon_c) : AW'(lon_c);
            av_reg     <= lat_c[ZW-1] ? AW'(-lat_c) : AW'(lat_c);
            mu_reg     <= {31'd0, au_reg} * {17'd0, radius};
            mv_reg     <= {31'd0, av_reg} * {17'd0, radius};
            nu_reg     <= su[48:15];
            nv_reg     <= sv[48:15];
            pu_reg[0]  <= part({1'b0, nu_reg[NB-1:17]}, RECIP[MW-1:17]);
            pu_reg[1]  <= part({1'b0, nu_reg[NB-1:17]}, {1'b0, RECIP[16:0]});
            pu_reg[2]  <= part({1'b0, nu_reg[16:0]}, RECIP[MW-1:17]);
            pu_reg[3]  <= part({1'b0, nu_reg[16:0]}, {1'b0, RECIP[16:0]});
            pv_reg[0]  <= part({1'b0, nv_reg[NB-1:17]}, RECIP[MW-1:17]);
            pv_reg[1]  <= part({1'b0, nv_reg[NB-1:17]}, {1'b0, RECIP[16:0]});
            pv_reg[2]  <= part({1'b0, nv_reg[16:0]}, RECIP[MW-1:17]);
            pv_reg[3]  <= part({1'b0, nv_reg[16:0]}, {1'b0, RECIP[16:0]});
            qu_reg     <= sum_u[SH +: NB];
            qv_reg     <= sum_v[SH +: NB];
        end
    end

    for (genvar p = 0; p < LAST; p++)
    begin : g_carry
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[p+1] <= 1'b0;
            else if (en)
                vld_reg[p+1] <= vld_reg[p];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lat_reg[p+1] <= lat_reg[p];
                lon_reg[p+1] <= lon_reg[p];
                cen_reg[p+1] <= cen_reg[p];
            end
        end
    end

    logic        vld_out_reg;
    logic [ZW-1:0] lat_out_reg;
    logic [ZW-1:0] lon_out_reg;
    logic [31:0] u_out_reg;
    logic [31:0] v_out_reg;
    logic        cen_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_out_reg <= 1'b0;
        else if (en)
            vld_out_reg <= vld_reg[LAST];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lat_out_reg <= lat_reg[LAST];
            lon_out_reg <= lon_reg[LAST];
            cen_out_reg <= cen_reg[LAST];
            u_out_reg   <= saturate(qu_reg, lon_reg[LAST][ZW-1]);
            v_out_reg   <= saturate(qv_reg, lat_reg[LAST][ZW-1]);
        end
    end

    assign out_vld    = vld_out_reg;
    assign out_lat    = lat_out_reg;
    assign out_lon    = lon_out_reg;
    assign out_u      = u_out_reg;
    assign out_v      = v_out_reg;
    assign out_centre = cen_out_reg;

endmodule

### rtl/point_to_latitude_longitude.sv
`timescale 1ns / 1ps
// Order: offset, longitude CORDIC, squares, square root, latitude CORDIC, noise.
// Throughput: one point per cycle; every stage is a register stage and the whole
// pipeline advances together whenever the result register is empty or taken.
// Reset: rst_n clears all valid bits and the centre and radius registers to zero.
// Depth is set by the two CORDIC chains and the 32-step square root.
module point_to_latitude_longitude #(
    parameter int WORLD_UNITS_PER_NODE = 10,
    parameter int ANGLE_ITERATIONS     = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ptll_pt_if.sink     pt,
    ptll_res_if.source  res
);

    localparam int DW = ptll_pkg::DW;
    localparam int CW = ptll_pkg::CW;
    localparam int ZW = ptll_pkg::ZW;

    logic [31:0] centre_x_reg;
    logic [31:0] centre_y_reg;
    logic [31:0] centre_z_reg;
    logic [30:0] radius_reg;
    ptll_pkg::cfg_reg_t sel;

    assign pready = 1'b1;
    assign sel    = ptll_pkg::cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_x_reg <= '0;
            centre_y_reg <= '0;
            centre_z_reg <= '0;
            radius_reg   <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (sel)
                ptll_pkg::REG_CENTRE_X:      centre_x_reg <= pwdata;
                ptll_pkg::REG_CENTRE_Y:      centre_y_reg <= pwdata;
                ptll_pkg::REG_CENTRE_Z:      centre_z_reg <= pwdata;
                ptll_pkg::REG_PLANET_RADIUS: radius_reg   <= pwdata[30:0];
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            ptll_pkg::REG_CENTRE_X:      prdata = centre_x_reg;
            ptll_pkg::REG_CENTRE_Y:      prdata = centre_y_reg;
            ptll_pkg::REG_CENTRE_Z:      prdata = centre_z_reg;
            ptll_pkg::REG_PLANET_RADIUS: prdata = {1'b0, radius_reg};
            default:                     prdata = '0;
        endcase
    end

    logic en;
    logic out_vld;

    assign en       = !out_vld || res.ready;
    assign pt.ready = en;

    // offset from centre
    logic                   vld0_reg;
    logic signed [DW-1:0]   dx_reg;
    logic signed [DW-1:0]   dy_reg;
    logic signed [DW-1:0]   dz_reg;
    logic                   cen0_reg;
    logic signed [DW-1:0]   dx_next;
    logic signed [DW-1:0]   dy_next;
    logic signed [DW-1:0]   dz_next;

    assign dx_next = $signed({pt.pos_x[31], pt.pos_x}) - $signed({centre_x_reg[31], centre_x_reg});
    assign dy_next = $signed({pt.pos_y[31], pt.pos_y}) - $signed({centre_y_reg[31], centre_y_reg});
    assign dz_next = $signed({pt.pos_z[31], pt.pos_z}) - $signed({centre_z_reg[31], centre_z_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld0_reg <= 1'b0;
        else if (en)
            vld0_reg <= pt.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            dz_reg   <= dz_next;
            cen0_reg <= (dx_next == '0) && (dy_next == '0) && (dz_next == '0);
        end
    end

    // longitude
    localparam int LSW = 1 + 3 * DW;
    logic                 lon_vld;
    logic signed [ZW-1:0] lon_z;
    logic [LSW-1:0]       lon_side;

    ptll_cordic #(.ITER(ANGLE_ITERATIONS), .SW(LSW)) u_lon (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vld0_reg),
        .in_y     (CW'(dx_reg)),
        .in_x     (CW'(dz_reg)),
        .in_side  ({cen0_reg, dx_reg, dy_reg, dz_reg}),
        .out_vld  (lon_vld),
        .out_z    (lon_z),
        .out_side (lon_side)
    );

    logic signed [DW-1:0] sdx;
    logic signed [DW-1:0] sdy;
    logic signed [DW-1:0] sdz;
    logic [DW-1:0]        adx;
    logic [DW-1:0]        adz;
    logic                 big;
    logic signed [DW-1:0] lx;
    logic signed [DW-1:0] ly;
    logic signed [DW-1:0] lz;
    logic [DW-1:0]        alx;
    logic [DW-1:0]        alz;

    assign sdx = $signed(lon_side[3*DW-1:2*DW]);
    assign sdy = $signed(lon_side[2*DW-1:DW]);
    assign sdz = $signed(lon_side[DW-1:0]);
    assign adx = sdx[DW-1] ? -sdx : sdx;
    assign adz = sdz[DW-1] ? -sdz : sdz;
    assign big = (adx[DW-1:31] != '0) || (adz[DW-1:31] != '0);
    assign lx  = big ? (sdx >>> 1) : sdx;
    assign ly  = big ? (sdy >>> 1) : sdy;
    assign lz  = big ? (sdz >>> 1) : sdz;
    assign alx = lx[DW-1] ? -lx : lx;
    assign alz = lz[DW-1] ? -lz : lz;

    logic                 sq_vld_reg;
    logic [63:0]          sqx_reg;
    logic [63:0]          sqz_reg;
    logic signed [DW-1:0] ly_reg;
    logic signed [ZW-1:0] lon_reg;
    logic                 cen1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_vld_reg <= 1'b0;
        else if (en)
            sq_vld_reg <= lon_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg  <= alx[31:0] * alx[31:0];
            sqz_reg  <= alz[31:0] * alz[31:0];
            ly_reg   <= ly;
            lon_reg  <= lon_z;
            cen1_reg <= lon_side[LSW-1];
        end
    end

    // horizontal distance
    localparam int QSW = 1 + ZW + DW;
    logic           rt_vld;
    logic [31:0]    rt;
    logic [QSW-1:0] rt_side;

    ptll_isqrt #(.SW(QSW)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (sq_vld_reg),
        .in_v     (sqx_reg + sqz_reg),
        .in_side  ({cen1_reg, lon_reg, ly_reg}),
        .out_vld  (rt_vld),
        .out_root (rt),
        .out_side (rt_side)
    );

    // latitude
    localparam int TSW = 1 + ZW;
    logic                 lat_vld;
    logic signed [ZW-1:0] lat_z;
    logic [TSW-1:0]       lat_side;

    ptll_cordic #(.ITER(ANGLE_ITERATIONS), .SW(TSW)) u_lat (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (rt_vld),
        .in_y     (CW'($signed(rt_side[DW-1:0]))),
        .in_x     ($signed({{(CW-32){1'b0}}, rt})),
        .in_side  (rt_side[QSW-1:DW]),
        .out_vld  (lat_vld),
        .out_z    (lat_z),
        .out_side (lat_side)
    );

    ptll_noise #(.WORLD_UNITS_PER_NODE(WORLD_UNITS_PER_NODE)) u_noise (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_vld     (lat_vld),
        .in_lat     (lat_z),
        .in_lon     ($signed(lat_side[ZW-1:0])),
        .in_centre  (lat_side[TSW-1]),
        .radius     (radius_reg),
        .out_vld    (out_vld),
        .out_lat    (res.latitude),
        .out_lon    (res.longitude),
        .out_u      (res.noise_u),
        .out_v      (res.noise_v),
        .out_centre (res.at_centre)
    );

    assign res.valid = out_vld;

endmodule
